### rtl/rate_monotonic_tick_scheduler_macros.svh
// Assertion macros for the rate-monotonic tick scheduler.
// Used by the top level only; no dependencies.
`ifndef RATE_MONOTONIC_TICK_SCHEDULER_MACROS_SVH
`define RATE_MONOTONIC_TICK_SCHEDULER_MACROS_SVH
// implication checked every clock outside reset
`define RMS_ASSERT_IMP(label, clk, rst_n, a, c, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) else $error(msg);
// next-cycle implication checked every clock outside reset
`define RMS_ASSERT_NXT(label, clk, rst_n, a, c, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) else $error(msg);
`endif

### rtl/rms_pkg.sv
// Package for the rate-monotonic tick scheduler: types and constants.
// No dependencies.
package rms_pkg;
    localparam int TAG_W = 8;
    localparam int PER_W = 16;
    localparam int TICK_W = 32;
    localparam logic [TICK_W-1:0] LAST_TICK_RST = 32'd1000;

    typedef enum logic [2:0] {
        ST_IDLE, ST_CHECK, ST_SCAN, ST_DISP, ST_OUT
    } t_state;

    // Per-tick command broadcast to every cell
    typedef struct packed {
        logic load;       // load this cell (slot match handled in cell)
        logic start;      // tick zero initialisation
        logic advance;    // release/countdown step of a normal tick
        logic charge_ok;  // running cell: charge it one unit
        logic clr_ready;  // clear ready of the selected cell
        logic set_ready;  // set ready of the preempted running cell
    } t_cell_cmd;

    // Candidate travelling along the chain
    typedef struct packed {
        logic             valid;
        logic [PER_W-1:0] period;
        logic [TAG_W-1:0] tag;
    } t_cand;
endpackage

### rtl/rms_cell.sv
// One task slot of the scheduler chain: holds the slot state and passes the
// best-ready and violation candidates on to its neighbour. Uses rms_pkg.
module rms_cell #(
    parameter int IDX_W = 3
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic [IDX_W-1:0]        i_idx,
    input  rms_pkg::t_cell_cmd      i_cmd,
    input  logic                    i_sel,       // this slot addressed by load
    input  logic                    i_running,   // this slot is running (busy)
    input  logic                    i_dispatch,  // this slot is being dispatched
    input  logic [rms_pkg::TAG_W-1:0] i_tag,
    input  logic [rms_pkg::PER_W-1:0] i_period,
    input  logic [rms_pkg::PER_W-1:0] i_budget,
    input  rms_pkg::t_cand          i_best,      // best ready from lower slots
    input  logic [IDX_W-1:0]        i_best_idx,
    input  logic                    i_miss,      // violation found in lower slots
    input  logic [rms_pkg::TAG_W-1:0] i_miss_tag,
    output rms_pkg::t_cand          o_best,
    output logic [IDX_W-1:0]        o_best_idx,
    output logic                    o_miss,
    output logic [rms_pkg::TAG_W-1:0] o_miss_tag,
    output logic [rms_pkg::TAG_W-1:0] o_tag,
    output logic [rms_pkg::PER_W-1:0] o_period,
    output logic                    o_finish     // charge would complete budget
);
    import rms_pkg::*;

    logic             r_loaded, r_ready;
    logic [TAG_W-1:0] r_tag;
    logic [PER_W-1:0] r_period, r_budget, r_used, r_count;
    logic             edge_hit, pend, viol;
    logic [PER_W:0]   used_inc;

    assign edge_hit = r_loaded && (r_count <= PER_W'(1));
    assign pend     = r_ready || i_running;
    assign viol     = edge_hit && pend && (r_used < r_budget);
    assign used_inc = {1'b0, r_used} + (PER_W+1)'(1);
    assign o_finish = used_inc >= {1'b0, r_budget};
    assign o_tag    = r_tag;
    assign o_period = r_period;

    always_comb begin
        o_miss     = i_miss;
        o_miss_tag = i_miss_tag;
        if (!i_miss && viol) begin
            o_miss     = 1'b1;
            o_miss_tag = r_tag;
        end
        o_best     = i_best;
        o_best_idx = i_best_idx;
        if (r_ready && (!i_best.valid || r_period < i_best.period)) begin
            o_best     = '{valid: 1'b1, period: r_period, tag: r_tag};
            o_best_idx = i_idx;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load && i_sel) begin
            r_tag    <= i_tag;
            r_period <= i_period;
            r_budget <= i_budget;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_loaded <= 1'b0;
            r_ready  <= 1'b0;
            r_used   <= '0;
            r_count  <= '0;
        end else if (i_cmd.load && i_sel) begin
            r_loaded <= 1'b1;
            r_ready  <= 1'b0;
            r_used   <= '0;
            r_count  <= i_period;
        end else if (i_cmd.start) begin
            r_ready <= r_loaded;
            r_used  <= '0;
            r_count <= r_period;
        end else if (i_cmd.advance) begin
            if (r_loaded) begin
                if (edge_hit) begin
                    r_count <= r_period;
                    if (!i_running) r_ready <= 1'b1;
                end else begin
                    r_count <= r_count - PER_W'(1);
                end
            end
        end else if (i_cmd.charge_ok && i_running) begin
            r_used <= o_finish ? '0 : used_inc[PER_W-1:0];
        end else begin
            if (i_cmd.clr_ready && i_dispatch) r_ready <= 1'b0;
            if (i_cmd.set_ready && i_running) r_ready <= 1'b1;
        end
    end
endmodule

### rtl/rms_chain.sv
// Row of scheduler cells with the best-ready and violation chains between
// neighbours. Uses rms_pkg and rms_cell.
module rms_chain #(
    parameter int TASK_SLOTS = 8,
    parameter int IDX_W = 3
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  rms_pkg::t_cell_cmd        i_cmd,
    input  logic [2:0]                i_load_slot,
    input  logic                      i_busy,
    input  logic [IDX_W-1:0]          i_run_idx,
    input  logic [IDX_W-1:0]          i_disp_idx,
    input  logic [rms_pkg::TAG_W-1:0] i_tag,
    input  logic [rms_pkg::PER_W-1:0] i_period,
    input  logic [rms_pkg::PER_W-1:0] i_budget,
    output rms_pkg::t_cand            o_best,
    output logic [IDX_W-1:0]          o_best_idx,
    output logic                      o_miss,
    output logic [rms_pkg::TAG_W-1:0] o_miss_tag,
    output logic [rms_pkg::TAG_W-1:0] o_run_tag,
    output logic [rms_pkg::PER_W-1:0] o_run_period,
    output logic                      o_run_finish
);
    import rms_pkg::*;

    t_cand            best  [TASK_SLOTS+1];
    logic [IDX_W-1:0] bidx  [TASK_SLOTS+1];
    logic             miss  [TASK_SLOTS+1];
    logic [TAG_W-1:0] mtag  [TASK_SLOTS+1];
    logic [TAG_W-1:0] tags  [TASK_SLOTS];
    logic [PER_W-1:0] pers  [TASK_SLOTS];
    logic             fins  [TASK_SLOTS];

    assign best[0] = '0;
    assign bidx[0] = '0;
    assign miss[0] = 1'b0;
    assign mtag[0] = '0;

    for (genvar g = 0; g < TASK_SLOTS; g++) begin : g_cell
        rms_cell #(.IDX_W(IDX_W)) u_cell (
            .i_clk      (i_clk),
            .i_rst_n    (i_rst_n),
            .i_idx      (IDX_W'(g)),
            .i_cmd      (i_cmd),
            .i_sel      ({29'd0, i_load_slot} == 32'(g)),
            .i_running  (i_busy && i_run_idx == IDX_W'(g)),
            .i_dispatch (i_disp_idx == IDX_W'(g)),
            .i_tag      (i_tag),
            .i_period   (i_period),
            .i_budget   (i_budget),
            .i_best     (best[g]),
            .i_best_idx (bidx[g]),
            .i_miss     (miss[g]),
            .i_miss_tag (mtag[g]),
            .o_best     (best[g+1]),
            .o_best_idx (bidx[g+1]),
            .o_miss     (miss[g+1]),
            .o_miss_tag (mtag[g+1]),
            .o_tag      (tags[g]),
            .o_period   (pers[g]),
            .o_finish   (fins[g])
        );
    end

    assign o_best       = best[TASK_SLOTS];
    assign o_best_idx   = bidx[TASK_SLOTS];
    assign o_miss       = miss[TASK_SLOTS];
    assign o_miss_tag   = mtag[TASK_SLOTS];
    assign o_run_tag    = tags[i_run_idx];
    assign o_run_period = pers[i_run_idx];
    assign o_run_finish = fins[i_run_idx];
endmodule

### rtl/rate_monotonic_tick_scheduler.sv
// Rate-monotonic tick scheduler for up to eight periodic tasks. A load transaction
// is taken on acceptance and loads may follow back to back. A tick transaction walks
// the row of slot cells in three steps (deadline check and release, charge of the
// running task, preemption and dispatch) and then registers its result.
// A halted tick, or one that flags a miss, skips the charge and dispatch steps.
// Input is blocked while a result waits for the receiver.
// Depends on rms_pkg, rms_chain, rms_cell and the assertion macro header.
module rate_monotonic_tick_scheduler #(
    parameter int TASK_SLOTS = 8
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [31:0] i_cfg_data,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic        i_opcode,
    input  logic [2:0]  i_slot,
    input  logic [7:0]  i_task_tag,
    input  logic [15:0] i_task_period,
    input  logic [15:0] i_task_budget,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [31:0] o_tick_now,
    output logic        o_finished_valid,
    output logic [7:0]  o_finished_tag,
    output logic        o_dispatch_valid,
    output logic [7:0]  o_dispatch_tag,
    output logic        o_miss_valid,
    output logic [7:0]  o_miss_tag,
    output logic        o_halted
);
    import rms_pkg::*;
`include "rate_monotonic_tick_scheduler_macros.svh"

    localparam int IDX_W = (TASK_SLOTS > 1) ? $clog2(TASK_SLOTS) : 1;

    t_state           r_state, n_state;
    logic [31:0]      r_last;
    logic             r_busy, r_stopped;
    logic [IDX_W-1:0] r_run;
    logic [31:0]      r_tick;
    logic             r_start;
    logic             r_fin_v, r_dsp_v, r_miss_v, r_halt;
    logic [7:0]       r_fin_t, r_dsp_t, r_miss_t;
    logic [31:0]      r_tnow;
    logic             r_ovalid;

    t_cell_cmd        cmd;
    t_cand            best;
    logic [IDX_W-1:0] best_idx;
    logic             miss;
    logic [7:0]       miss_tag, run_tag;
    logic [15:0]      run_per;
    logic             run_fin;
    logic             acc, load_acc, tick_acc, slot_ok;

    assign acc      = i_valid && o_ready;
    assign load_acc = acc && !i_opcode;
    assign tick_acc = acc && i_opcode;
    assign slot_ok  = {29'd0, i_slot} < 32'(TASK_SLOTS);

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE:  if (tick_acc) n_state = ST_CHECK;
            ST_CHECK: n_state = (r_halt || miss) ? ST_OUT : ST_SCAN;
            ST_SCAN:  n_state = ST_DISP;
            ST_DISP:  n_state = ST_OUT;
            ST_OUT:   if (!r_ovalid || i_ready) n_state = ST_IDLE;
            default:  n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        o_ready = (r_state == ST_IDLE) && !r_ovalid;
        cmd = '0;
        cmd.load = load_acc && slot_ok;
        unique case (r_state)
            ST_CHECK: begin
                cmd.start   = !r_halt && r_start;
                cmd.advance = !r_halt && !r_start && !miss;
            end
            ST_SCAN:  cmd.charge_ok = !r_start && r_busy;
            ST_DISP:  begin
                cmd.clr_ready = 1'b1;
                cmd.set_ready = 1'b0;
            end
            default: ;
        endcase
    end

    // preempt decision taken in ST_DISP; the preempted slot's ready is set
    // through set_ready in the same cycle the new one is cleared
    logic preempt, disp_now;
    always_comb begin
        preempt  = r_busy && best.valid && best.period < run_per;
        disp_now = best.valid && (!r_busy || preempt);
    end

    t_cell_cmd cmd_x;
    always_comb begin
        cmd_x = cmd;
        if (r_state == ST_DISP) begin
            cmd_x.clr_ready = disp_now;
            cmd_x.set_ready = disp_now && r_busy;
        end
    end

    rms_chain #(.TASK_SLOTS(TASK_SLOTS), .IDX_W(IDX_W)) u_chain (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (cmd_x),
        .i_load_slot  (i_slot),
        .i_busy       (r_busy),
        .i_run_idx    (r_run),
        .i_disp_idx   (best_idx),
        .i_tag        (i_task_tag),
        .i_period     (i_task_period),
        .i_budget     (i_task_budget),
        .o_best       (best),
        .o_best_idx   (best_idx),
        .o_miss       (miss),
        .o_miss_tag   (miss_tag),
        .o_run_tag    (run_tag),
        .o_run_period (run_per),
        .o_run_finish (run_fin)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_last    <= LAST_TICK_RST;
            r_busy    <= 1'b0;
            r_run     <= '0;
            r_tick    <= '0;
            r_stopped <= 1'b0;
            r_start   <= 1'b0;
            r_ovalid  <= 1'b0;
            r_fin_v   <= 1'b0;
            r_dsp_v   <= 1'b0;
            r_miss_v  <= 1'b0;
            r_halt    <= 1'b0;
            r_fin_t   <= '0;
            r_dsp_t   <= '0;
            r_miss_t  <= '0;
            r_tnow    <= '0;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) r_last <= i_cfg_data;
            if (o_valid && i_ready) r_ovalid <= 1'b0;
            if (load_acc && slot_ok && r_busy && {29'd0, i_slot} == 32'(r_run))
                r_busy <= 1'b0;
            unique case (r_state)
                ST_IDLE: if (tick_acc) begin
                    r_tnow   <= r_tick;
                    r_start  <= r_tick == 32'd0;
                    r_halt   <= r_stopped || r_tick > r_last;
                    r_fin_v  <= 1'b0;
                    r_dsp_v  <= 1'b0;
                    r_miss_v <= 1'b0;
                    r_fin_t  <= '0;
                    r_dsp_t  <= '0;
                    r_miss_t <= '0;
                end
                ST_CHECK: begin
                    if (!r_halt && r_start) r_busy <= 1'b0;
                    if (!r_halt && !r_start && miss) begin
                        r_stopped <= 1'b1;
                        r_miss_v  <= 1'b1;
                        r_miss_t  <= miss_tag;
                        r_halt    <= 1'b1;
                    end
                end
                ST_SCAN: if (!r_start && r_busy && run_fin) begin
                    r_busy  <= 1'b0;
                    r_fin_v <= 1'b1;
                    r_fin_t <= run_tag;
                end
                ST_DISP: begin
                    if (disp_now) begin
                        r_busy  <= 1'b1;
                        r_run   <= best_idx;
                        r_dsp_v <= 1'b1;
                        r_dsp_t <= best.tag;
                    end
                    if (r_tick == 32'hFFFF_FFFF) r_stopped <= 1'b1;
                    else r_tick <= r_tick + 32'd1;
                end
                ST_OUT: if (!r_ovalid || i_ready) r_ovalid <= 1'b1;
                default: ;
            endcase
        end
    end

    assign o_valid          = r_ovalid && r_state == ST_IDLE;
    assign o_tick_now       = r_tnow;
    assign o_finished_valid = r_fin_v;
    assign o_finished_tag   = r_fin_t;
    assign o_dispatch_valid = r_dsp_v;
    assign o_dispatch_tag   = r_dsp_t;
    assign o_miss_valid     = r_miss_v;
    assign o_miss_tag       = r_miss_t;
    assign o_halted         = r_halt;

    `RMS_ASSERT_IMP(a_miss_halts, i_clk, i_rst_n, o_valid && o_miss_valid, o_halted, "miss without halt")
    `RMS_ASSERT_IMP(a_halt_quiet, i_clk, i_rst_n, o_valid && o_halted, !o_finished_valid && !o_dispatch_valid, "activity on halted tick")
    `RMS_ASSERT_NXT(a_disp_busy, i_clk, i_rst_n, r_state == ST_DISP && disp_now, r_busy && r_run == $past(best_idx), "dispatch lost")
    `RMS_ASSERT_IMP(a_no_accept_busy, i_clk, i_rst_n, r_state != ST_IDLE, !o_ready, "accept while working")
endmodule

### sim/rate_monotonic_tick_scheduler_tb.sv
// Self-checking testbench for the rate-monotonic tick scheduler: a directed table,
// random task loads and ticks, then a second directed table, checked against a
// behavioural scheduler model. Depends on the RTL of rate_monotonic_tick_scheduler.
`timescale 1ns / 100ps

module rate_monotonic_tick_scheduler_tb;

    localparam int SLOTS = 8;
    localparam int QUIET_LIMIT = 2000;

    typedef enum bit {OP_LOAD = 1'b0, OP_TICK = 1'b1} op_e;
    typedef enum bit [1:0] {ROW_ITEM, ROW_LIT, ROW_CFG} row_kind_e;

    typedef struct packed {
        op_e         op;
        logic [2:0]  slot;
        logic [7:0]  tag;
        logic [15:0] period;
        logic [15:0] budget;
    } sched_item_t;

    typedef struct packed {
        logic [31:0] tick;
        logic        fin_v;
        logic [7:0]  fin_tag;
        logic        disp_v;
        logic [7:0]  disp_tag;
        logic        miss_v;
        logic [7:0]  miss_tag;
        logic        halted;
    } tick_res_t;

    typedef struct packed {
        row_kind_e   kind;
        sched_item_t item;
        tick_res_t   lit;
        logic [31:0] cfg;
    } row_t;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_cfg_we = 1'b0;
    logic [31:0] i_cfg_data = '0;
    logic        i_valid = 1'b0;
    logic        o_ready;
    logic        i_opcode = 1'b0;
    logic [2:0]  i_slot = '0;
    logic [7:0]  i_task_tag = '0;
    logic [15:0] i_task_period = '0;
    logic [15:0] i_task_budget = '0;
    logic        o_valid;
    logic        i_ready = 1'b0;
    logic [31:0] o_tick_now;
    logic        o_finished_valid;
    logic [7:0]  o_finished_tag;
    logic        o_dispatch_valid;
    logic [7:0]  o_dispatch_tag;
    logic        o_miss_valid;
    logic [7:0]  o_miss_tag;
    logic        o_halted;

    rate_monotonic_tick_scheduler dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cfg_we(i_cfg_we), .i_cfg_data(i_cfg_data),
        .i_valid(i_valid), .o_ready(o_ready),
        .i_opcode(i_opcode), .i_slot(i_slot), .i_task_tag(i_task_tag),
        .i_task_period(i_task_period), .i_task_budget(i_task_budget),
        .o_valid(o_valid), .i_ready(i_ready),
        .o_tick_now(o_tick_now),
        .o_finished_valid(o_finished_valid), .o_finished_tag(o_finished_tag),
        .o_dispatch_valid(o_dispatch_valid), .o_dispatch_tag(o_dispatch_tag),
        .o_miss_valid(o_miss_valid), .o_miss_tag(o_miss_tag),
        .o_halted(o_halted)
    );

    always #2 i_clk = ~i_clk;

    // scheduler model state
    logic [31:0] m_last_tick;
    bit          m_loaded [SLOTS];
    logic [7:0]  m_tag [SLOTS];
    logic [15:0] m_period [SLOTS];
    logic [15:0] m_budget [SLOTS];
    logic [15:0] m_used [SLOTS];
    logic [15:0] m_countdown [SLOTS];
    bit          m_ready [SLOTS];
    bit          m_busy;
    int          m_running;
    logic [31:0] m_tick;
    bit          m_stopped;

    tick_res_t exp_ticks [$];
    int  errors = 0;
    int  src_idle = 0;
    int  snk_idle = 0;
    int  quiet = 0;
    int  n_ticks = 0, n_loads = 0, n_miss = 0, n_halt = 0, n_disp = 0;

    function automatic int best_ready();
        int b;
        b = -1;
        for (int i = 0; i < SLOTS; i++)
            if (m_ready[i] && (b < 0 || m_period[i] < m_period[b]))
                b = i;
        return b;
    endfunction

    function automatic void run_task(input int s, inout tick_res_t r);
        m_ready[s] = 0;
        m_busy = 1;
        m_running = s;
        r.disp_v = 1'b1;
        r.disp_tag = m_tag[s];
    endfunction

    function automatic bit schedule_item(input sched_item_t it, output tick_res_t r);
        int b;
        int s;
        bit edge_f [SLOTS];
        bit pend;
        logic [31:0] t;
        logic [16:0] u;
        r = '0;
        if (it.op == OP_LOAD) begin
            s = int'(it.slot);
            m_loaded[s] = 1;
            m_tag[s] = it.tag;
            m_period[s] = it.period;
            m_budget[s] = it.budget;
            m_used[s] = '0;
            m_ready[s] = 0;
            m_countdown[s] = it.period;
            if (m_busy && m_running == s)
                m_busy = 0;
            return 1'b0;
        end
        t = m_tick;
        r.tick = t;
        if (m_stopped || t > m_last_tick) begin
            r.halted = 1'b1;
            return 1'b1;
        end
        if (t == 0) begin
            for (int i = 0; i < SLOTS; i++) begin
                m_ready[i] = m_loaded[i];
                m_used[i] = '0;
                m_countdown[i] = m_period[i];
            end
            m_busy = 0;
            b = best_ready();
            if (b >= 0)
                run_task(b, r);
        end else begin
            for (int i = 0; i < SLOTS; i++)
                edge_f[i] = m_loaded[i] && m_countdown[i] <= 1;
            for (int i = 0; i < SLOTS; i++) begin
                pend = m_ready[i] || (m_busy && m_running == i);
                if (edge_f[i] && pend && m_used[i] < m_budget[i]) begin
                    m_stopped = 1;
                    r.miss_v = 1'b1;
                    r.miss_tag = m_tag[i];
                    r.halted = 1'b1;
                    return 1'b1;
                end
            end
            for (int i = 0; i < SLOTS; i++) begin
                if (m_loaded[i]) begin
                    if (edge_f[i]) begin
                        m_countdown[i] = m_period[i];
                        if (!(m_busy && m_running == i))
                            m_ready[i] = 1;
                    end else begin
                        m_countdown[i] = m_countdown[i] - 16'd1;
                    end
                end
            end
            if (m_busy) begin
                s = m_running;
                u = {1'b0, m_used[s]} + 17'd1;
                if (u >= {1'b0, m_budget[s]}) begin
                    m_used[s] = '0;
                    m_busy = 0;
                    r.fin_v = 1'b1;
                    r.fin_tag = m_tag[s];
                end else begin
                    m_used[s] = u[15:0];
                    b = best_ready();
                    if (b >= 0 && m_period[b] < m_period[s]) begin
                        m_ready[s] = 1;
                        run_task(b, r);
                    end
                end
            end
            if (!m_busy) begin
                b = best_ready();
                if (b >= 0)
                    run_task(b, r);
            end
        end
        if (t == 32'hFFFF_FFFF)
            m_stopped = 1;
        else
            m_tick = t + 32'd1;
        return 1'b1;
    endfunction

    task automatic send_item(input sched_item_t it, input bit use_lit, input tick_res_t lit);
        tick_res_t r;
        if ($urandom_range(0, 99) < src_idle) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_opcode <= it.op;
        i_slot <= it.slot;
        i_task_tag <= it.tag;
        i_task_period <= it.period;
        i_task_budget <= it.budget;
        do @(posedge i_clk); while (!o_ready);
        if (schedule_item(it, r)) begin
            exp_ticks.insert(exp_ticks.size(), use_lit ? lit : r);
            n_ticks++;
        end else begin
            n_loads++;
        end
    endtask

    task automatic write_last_tick(input logic [31:0] v);
        i_valid <= 1'b0;
        while (exp_ticks.size() != 0) @(posedge i_clk);
        repeat (12) @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_data <= v;
        m_last_tick = v;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    function automatic row_t ld(input int s, input int tg, input int p, input int bd);
        row_t w;
        w = '0;
        w.kind = ROW_ITEM;
        w.item = '{OP_LOAD, s[2:0], tg[7:0], p[15:0], bd[15:0]};
        return w;
    endfunction

    function automatic row_t tk();
        row_t w;
        w = '0;
        w.kind = ROW_ITEM;
        w.item.op = OP_TICK;
        return w;
    endfunction

    function automatic row_t tk_lit(input tick_res_t r);
        row_t w;
        w = tk();
        w.kind = ROW_LIT;
        w.lit = r;
        return w;
    endfunction

    function automatic row_t cf(input logic [31:0] v);
        row_t w;
        w = '0;
        w.kind = ROW_CFG;
        w.cfg = v;
        return w;
    endfunction

    task automatic walk_rows(input row_t rows [$]);
        foreach (rows[k]) begin
            if (rows[k].kind == ROW_CFG)
                write_last_tick(rows[k].cfg);
            else
                send_item(rows[k].item, rows[k].kind == ROW_LIT, rows[k].lit);
        end
    endtask

    function automatic sched_item_t random_item();
        sched_item_t it;
        int sel;
        int p;
        sel = $urandom_range(0, 99);
        it = '0;
        it.slot = 3'($urandom_range(0, 7));
        it.tag = 8'($urandom_range(0, 255));
        if (sel < 75) begin
            it.op = OP_TICK;
        end else if (sel < 95) begin
            // schedulable set: each task at most a sixteenth of the processor
            p = $urandom_range(16, 64);
            it.op = OP_LOAD;
            it.period = 16'(p);
            it.budget = 16'($urandom_range(1, p / 16));
        end else begin
            // long-period task that never reaches a boundary within the run
            it.op = OP_LOAD;
            it.period = 16'($urandom_range(4096, 65535));
            it.budget = 16'($urandom_range(0, 65535));
        end
        return it;
    endfunction

    task automatic check_field(input string nm, input logic [31:0] e, input logic [31:0] a);
        if (e !== a) begin
            $display("%0t: %s mismatch expected %0h actual %0h", $realtime, nm, e, a);
            errors++;
        end
    endtask

    always @(posedge i_clk) begin
        tick_res_t e;
        if (i_rst_n && o_valid && i_ready) begin
            if (exp_ticks.size() == 0) begin
                $display("%0t: unexpected result tick %0d", $realtime, o_tick_now);
                errors++;
            end else begin
                e = exp_ticks[0];
                exp_ticks.delete(0);
                check_field("tick_now", e.tick, o_tick_now);
                check_field("finished_valid", 32'(e.fin_v), 32'(o_finished_valid));
                check_field("finished_tag", 32'(e.fin_tag), 32'(o_finished_tag));
                check_field("dispatch_valid", 32'(e.disp_v), 32'(o_dispatch_valid));
                check_field("dispatch_tag", 32'(e.disp_tag), 32'(o_dispatch_tag));
                check_field("miss_valid", 32'(e.miss_v), 32'(o_miss_valid));
                check_field("miss_tag", 32'(e.miss_tag), 32'(o_miss_tag));
                check_field("halted", 32'(e.halted), 32'(o_halted));
                n_miss += int'(o_miss_valid);
                n_halt += int'(o_halted);
                n_disp += int'(o_dispatch_valid);
            end
        end
        i_ready <= ($urandom_range(0, 99) >= snk_idle);
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_valid && o_ready) || (o_valid && i_ready))
            quiet <= 0;
        else
            quiet <= quiet + 1;
        if (quiet >= QUIET_LIMIT) begin
            $display("%0t: no transaction for %0d cycles", $realtime, QUIET_LIMIT);
            $display("FAIL rate_monotonic_tick_scheduler");
            $finish;
        end
    end

    initial begin
        row_t head [$];
        row_t tail [$];
        tick_res_t r0, rh;
        r0 = '0;
        r0.disp_v = 1'b1;
        r0.disp_tag = 8'h11;
        rh = '0;
        rh.tick = 32'd10;
        rh.halted = 1'b1;
        head = {ld(0, 'h11, 4, 1), ld(5, 'hFF, 4, 1), ld(7, 'h00, 'hFFFF, 'hFFFF),
                tk_lit(r0), tk(), tk(), ld(1, 'h33, 8, 2), tk(), tk(), tk(),
                ld(0, 'h22, 6, 1), tk(), tk(), tk(), tk(),
                cf(32'd0), tk_lit(rh), cf(32'hFFFF_FFFF), tk()};
        // period zero, budget zero, then a task that cannot meet its deadline
        tail = {ld(2, 'hA5, 0, 0), tk(), tk(), tk(), ld(6, 'h5A, 2, 3),
                tk(), tk(), tk(), tk(), tk(), tk(), tk(), tk()};

        m_last_tick = 32'd1000;
        for (int i = 0; i < SLOTS; i++) begin
            m_loaded[i] = 0; m_tag[i] = '0; m_period[i] = '0; m_budget[i] = '0;
            m_used[i] = '0; m_countdown[i] = '0; m_ready[i] = 0;
        end
        m_busy = 0; m_running = 0; m_tick = '0; m_stopped = 0;

        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        src_idle = 15;
        snk_idle = 53;
        walk_rows(head);
        for (int ph = 0; ph < 3; ph++) begin
            case (ph)
                0: begin
                    write_last_tick(m_tick + $urandom_range(150, 300));
                end
                1: begin
                    src_idle = 53;
                    snk_idle = 15;
                    write_last_tick(32'hFFFF_FFFF);
                end
                default: begin
                    src_idle = 0;
                    snk_idle = 0;
                    write_last_tick(32'hFFFF_FFFE);
                end
            endcase
            for (int n = 0; n < 400; n++)
                send_item(random_item(), 1'b0, '0);
        end
        walk_rows(tail);
        i_valid <= 1'b0;
        while (exp_ticks.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);

        $display("Run covered %0d ticks and %0d task loads under three idle mixes;",
                 n_ticks, n_loads);
        $display("  %0d dispatches, %0d halted ticks, %0d deadline misses seen.",
                 n_disp, n_halt, n_miss);
        if (errors == 0) begin
            $display("PASS rate_monotonic_tick_scheduler");
        end else begin
            $display("FAIL rate_monotonic_tick_scheduler");
        end
        $finish;
    end

endmodule
